/* rtl/core/slcdw_pkg.sv */
// slcdw_pkg: shared types, codes, font and pin tables for the segment lcd writer
// depends on nothing; used by slcdw_digit and the top level
`default_nettype none

package slcdw_pkg;

    localparam int unsigned NUM_POSITIONS = 6;
    localparam int unsigned REST_W        = 20;   // values below one million
    localparam int unsigned GLYPH_W       = 6;

    localparam logic [2:0]  LAST_SLOT   = 3'(NUM_POSITIONS - 1);
    localparam logic [31:0] ERROR_LIMIT = 32'd1000000;

    localparam logic CMD_CHAR   = 1'b0;
    localparam logic CMD_NUMBER = 1'b1;

    localparam logic [GLYPH_W-1:0] GLYPH_STAR  = 6'd36;
    localparam logic [GLYPH_W-1:0] GLYPH_HASH  = 6'd37;
    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 6'd38;
    localparam logic [GLYPH_W-1:0] GLYPH_ALLON = 6'd39;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  char_code;
        logic [2:0]  position;
        logic [31:0] number_value;
    } t_in_item;

    typedef struct packed {
        logic [5:0] segment_pin;
        logic [3:0] nibble;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [3:0]        digit;
        logic [REST_W-1:0] rest;
    } t_digit;

    // decimal weight of each slot, most significant first
    function automatic logic [16:0] weight_of(input logic [2:0] slot);
        logic [16:0] w;
        unique case (slot)
            3'd0:    w = 17'd100000;
            3'd1:    w = 17'd10000;
            3'd2:    w = 17'd1000;
            3'd3:    w = 17'd100;
            3'd4:    w = 17'd10;
            default: w = 17'd1;
        endcase
        return w;
    endfunction

    // first segment pin of each slot; the four pins of a slot are consecutive
    function automatic logic [5:0] pin_of(input logic [2:0] slot, input logic [1:0] k);
        logic [5:0] base;
        unique case (slot)
            3'd0:    base = 6'd18;
            3'd1:    base = 6'd10;
            3'd2:    base = 6'd6;
            3'd3:    base = 6'd36;
            3'd4:    base = 6'd28;
            default: base = 6'd14;
        endcase
        return base + {4'b0, k};
    endfunction

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [7:0] ch);
        logic [GLYPH_W-1:0] g;
        if (ch == 8'h20) begin
            g = GLYPH_SPACE;
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            g = 6'(ch - 8'h30);
        end else if (ch >= 8'h41 && ch <= 8'h5A) begin
            g = 6'(ch - 8'h37);
        end else if (ch == 8'h2A) begin
            g = GLYPH_STAR;
        end else if (ch == 8'h23) begin
            g = GLYPH_HASH;
        end else begin
            g = GLYPH_ALLON;
        end
        return g;
    endfunction

    // " ERROR" text, one character per slot
    function automatic logic [7:0] err_char(input logic [2:0] slot);
        logic [7:0] c;
        unique case (slot)
            3'd0:    c = 8'h20;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h52;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4F;
            default: c = 8'h52;
        endcase
        return c;
    endfunction

    // font word {byte1, byte0}; nibble k sits at bits 4k+3..4k
    function automatic logic [15:0] font_of(input logic [GLYPH_W-1:0] g);
        logic [15:0] f;
        unique case (g)
            6'd0:  f = 16'h28FC;
            6'd1:  f = 16'h2060;
            6'd2:  f = 16'h00DB;
            6'd3:  f = 16'h00F1;
            6'd4:  f = 16'h0067;
            6'd5:  f = 16'h00B7;
            6'd6:  f = 16'h00BF;
            6'd7:  f = 16'h00E0;
            6'd8:  f = 16'h00FF;
            6'd9:  f = 16'h00F7;
            6'd10: f = 16'h00EF;
            6'd11: f = 16'h50F1;
            6'd12: f = 16'h009C;
            6'd13: f = 16'h50F0;
            6'd14: f = 16'h009E;
            6'd15: f = 16'h008E;
            6'd16: f = 16'h00BD;
            6'd17: f = 16'h006F;
            6'd18: f = 16'h5090;
            6'd19: f = 16'h0078;
            6'd20: f = 16'h220E;
            6'd21: f = 16'h001C;
            6'd22: f = 16'hA06C;
            6'd23: f = 16'h826C;
            6'd24: f = 16'h00FC;
            6'd25: f = 16'h00CF;
            6'd26: f = 16'h02FC;
            6'd27: f = 16'h02CF;
            6'd28: f = 16'h00B7;
            6'd29: f = 16'h5080;
            6'd30: f = 16'h007C;
            6'd31: f = 16'h280C;
            6'd32: f = 16'h0A6C;
            6'd33: f = 16'hAA00;
            6'd34: f = 16'hB000;
            6'd35: f = 16'h2890;
            6'd36: f = 16'hAA03;
            6'd37: f = 16'h50FF;
            6'd38: f = 16'h0000;
            default: f = 16'hFFFF;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/slcdw_chan_if.sv */
// slcdw_chan_if: valid/ready channel carrying one item of payload type T
// depends on nothing; the payload type comes in as a parameter
`default_nettype none

interface slcdw_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/slcdw_digit.sv */
// slcdw_digit: one decimal digit and remainder of a value below ten times the slot weight
// depends on slcdw_pkg
`default_nettype none

module slcdw_digit (
    input  wire logic [slcdw_pkg::REST_W-1:0] i_rest,
    input  wire logic [2:0]                   i_slot,
    output slcdw_pkg::t_digit                 o_res
);
    import slcdw_pkg::*;

    logic [16:0]       w;
    logic [REST_W-1:0] mult;
    logic [REST_W-1:0] sub;
    logic [3:0]        digit;

    // parallel compares against the nine multiples, largest hit wins
    always_comb begin
        w     = weight_of(i_slot);
        sub   = '0;
        digit = '0;
        mult  = '0;
        for (int m = 1; m <= 9; m++) begin
            mult = 20'(m) * {3'b0, w};
            if (i_rest >= mult) begin
                digit = 4'(m);
                sub   = mult;
            end
        end
    end

    assign o_res.digit = digit;
    assign o_res.rest  = i_rest - sub;

endmodule

`default_nettype wire

/* rtl/core/segment_lcd_char_and_number_writer_unit.sv */
// segment_lcd_char_and_number_writer_unit: top level of the six-position lcd writer
// depends on slcdw_pkg, slcdw_chan_if and slcdw_digit
//
// Turns a command item into nibble writes for a six-position segmented lcd. Command 0 draws
// char_code at position 1..6 as four writes (low/high nibble of font byte 0, then of byte 1)
// to that position's four segment pins; position 0 or 7 is accepted and gives no writes.
// Command 1 shows number_value right-aligned over all six positions as 24 writes, leading
// zeros blanked, and a value of one million or more shows " ERROR". The final write of each
// item carries last_of_run. Writes leave through one output register, one per cycle while the
// output is ready; the next item is accepted in the cycle the current item's last write is
// loaded, even while that write still waits downstream. Reset clears only the active and
// output-valid flags; no state is kept between items.
`default_nettype none

module segment_lcd_char_and_number_writer_unit (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    slcdw_chan_if.sink   i_in,
    slcdw_chan_if.source o_out
);
    import slcdw_pkg::*;

    // current item being expanded into writes
    logic                r_active, n_active;
    logic                r_cmd,    n_cmd;
    logic [7:0]          r_char,   n_char;
    logic [2:0]          r_slot,   n_slot;
    logic [1:0]          r_k,      n_k;
    logic [REST_W-1:0]   r_rest,   n_rest;
    logic                r_seen,   n_seen;
    logic                r_err,    n_err;

    // output register
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out,       n_out;

    t_digit              dig;
    logic [GLYPH_W-1:0]  glyph;
    logic [15:0]         font_word;
    logic                last;
    logic                out_free;
    logic                emit;
    logic                done;
    logic                in_ready;
    logic                accept;
    t_in_item            in_item;

    // digit of the current slot from the running remainder
    slcdw_digit u_digit (
        .i_rest (r_rest),
        .i_slot (r_slot),
        .o_res  (dig)
    );

    assign in_item = i_in.data;

    // glyph for the current slot
    always_comb begin
        if (r_cmd == CMD_CHAR) begin
            glyph = glyph_of(r_char);
        end else if (r_err) begin
            glyph = glyph_of(err_char(r_slot));
        end else if (dig.digit == 4'd0 && !r_seen && r_slot != LAST_SLOT) begin
            glyph = GLYPH_SPACE;   // leading zero
        end else begin
            glyph = {2'b0, dig.digit};
        end
    end

    assign font_word = font_of(glyph);
    assign last      = (r_k == 2'd3) && (r_cmd == CMD_CHAR || r_slot == LAST_SLOT);

    // handshake: a write moves into the output register when it is empty or draining
    assign out_free = !r_out_valid || o_out.ready;
    assign emit     = r_active && out_free;
    assign done     = emit && last;
    assign in_ready = !r_active || done;
    assign accept   = i_in.valid && in_ready;

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        n_active    = r_active;
        n_cmd       = r_cmd;
        n_char      = r_char;
        n_slot      = r_slot;
        n_k         = r_k;
        n_rest      = r_rest;
        n_seen      = r_seen;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (emit) begin
            n_out.segment_pin = pin_of(r_slot, r_k);
            n_out.nibble      = font_word[{r_k, 2'b00} +: 4];
            n_out.last_of_run = last;
            n_out_valid       = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (accept) begin
            n_cmd  = in_item.cmd;
            n_char = in_item.char_code;
            n_k    = 2'd0;
            n_rest = in_item.number_value[REST_W-1:0];
            n_seen = 1'b0;
            n_err  = in_item.number_value >= ERROR_LIMIT;
            if (in_item.cmd == CMD_NUMBER) begin
                n_active = 1'b1;
                n_slot   = 3'd0;
            end else begin
                // positions outside 1..6 give no writes
                n_active = (in_item.position >= 3'd1) &&
                           (in_item.position <= 3'(NUM_POSITIONS));
                n_slot   = in_item.position - 3'd1;
            end
        end else if (emit) begin
            n_k = r_k + 2'd1;
            if (r_k == 2'd3) begin
                if (last) begin
                    n_active = 1'b0;
                end else begin
                    n_slot = r_slot + 3'd1;
                    n_rest = dig.rest;
                    n_seen = r_seen || (dig.digit != 4'd0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
        r_cmd  <= n_cmd;
        r_char <= n_char;
        r_slot <= n_slot;
        r_k    <= n_k;
        r_rest <= n_rest;
        r_seen <= n_seen;
        r_err  <= n_err;
        r_out  <= n_out;
    end

    // the slot counter never leaves the display
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_slot <= LAST_SLOT)
        else $error("slot counter beyond last position");

    // the running remainder stays below ten times the current weight
    a_rest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && r_cmd == CMD_NUMBER && !r_err) |->
            ({4'b0, r_rest} < 24'(weight_of(r_slot)) * 24'd10))
        else $error("decimal remainder out of range");

    // an out-of-range position leaves the writer idle
    a_bad_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_item.cmd == CMD_CHAR &&
         (in_item.position == 3'd0 || in_item.position == 3'd7)) |=> !r_active)
        else $error("out-of-range position started a run");

    // the final write of an item shows up flagged in the output register
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (r_out_valid && r_out.last_of_run))
        else $error("last write of an item not flagged");

endmodule

`default_nettype wire

/* tb/tb_segment_lcd_char_and_number_writer_unit.sv */
// tb_segment_lcd_char_and_number_writer_unit: self-checking bench for the six-position lcd writer
// depends on slcdw_pkg, slcdw_chan_if and segment_lcd_char_and_number_writer_unit
// predicts every segment write from the command item and checks them in order

module tb_segment_lcd_char_and_number_writer_unit;

    import slcdw_pkg::*;

    // a long run of cycles with no item moving on either channel means the block hung
    localparam int STUCK_LIMIT = 2000;
    // idle stretch at the end so any stray trailing write still shows up
    localparam int DRAIN_CYCLES = 40;

    logic i_clk;
    logic i_rst_n;

    slcdw_chan_if #(.T(t_in_item))  in_ch  ();
    slcdw_chan_if #(.T(t_out_item)) out_ch ();

    segment_lcd_char_and_number_writer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // font words as {byte 0, byte 1}; glyph codes 0..9 digits, 10..35 capitals,
    // then star, hash, blank and the all-segments pattern
    bit [0:1][7:0] seg_font [40] = '{
        {8'hFC, 8'h28}, {8'h60, 8'h20}, {8'hDB, 8'h00}, {8'hF1, 8'h00}, {8'h67, 8'h00},
        {8'hB7, 8'h00}, {8'hBF, 8'h00}, {8'hE0, 8'h00}, {8'hFF, 8'h00}, {8'hF7, 8'h00},
        {8'hEF, 8'h00}, {8'hF1, 8'h50}, {8'h9C, 8'h00}, {8'hF0, 8'h50}, {8'h9E, 8'h00},
        {8'h8E, 8'h00}, {8'hBD, 8'h00}, {8'h6F, 8'h00}, {8'h90, 8'h50}, {8'h78, 8'h00},
        {8'h0E, 8'h22}, {8'h1C, 8'h00}, {8'h6C, 8'hA0}, {8'h6C, 8'h82}, {8'hFC, 8'h00},
        {8'hCF, 8'h00}, {8'hFC, 8'h02}, {8'hCF, 8'h02}, {8'hB7, 8'h00}, {8'h80, 8'h50},
        {8'h7C, 8'h00}, {8'h0C, 8'h28}, {8'h6C, 8'h0A}, {8'h00, 8'hAA}, {8'h00, 8'hB0},
        {8'h90, 8'h28}, {8'h03, 8'hAA}, {8'hFF, 8'h50}, {8'h00, 8'h00}, {8'hFF, 8'hFF}
    };

    // segment pins of each display position, in write order
    bit [5:0] pos_pins [6][4] = '{
        '{18, 19, 20, 21}, '{10, 11, 12, 13}, '{ 6,  7,  8,  9},
        '{36, 37, 38, 39}, '{28, 29, 30, 31}, '{14, 15, 16, 17}
    };

    int unsigned dec_weight [6] = '{100000, 10000, 1000, 100, 10, 1};
    logic [7:0]  error_text [6] = '{" ", "E", "R", "R", "O", "R"};

    // segment writes predicted but not yet seen on the output
    t_out_item pending_writes[$];

    int mismatches   = 0;
    int unexpected   = 0;
    int writes_seen  = 0;
    int char_items   = 0;
    int blank_items  = 0;
    int number_items = 0;
    int error_items  = 0;

    // idling knobs, changed by the test tasks
    bit tx_gaps        = 1'b1;
    bit rx_stalls      = 1'b1;
    int rx_hold_cycles = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // character code to glyph code
    function automatic logic [5:0] char_glyph(input logic [7:0] ch);
        if (ch == " ") return GLYPH_SPACE;
        if (ch >= "0" && ch <= "9") return 6'(ch - "0");
        if (ch >= "A" && ch <= "Z") return 6'(ch - "A" + 8'd10);
        if (ch == "*") return GLYPH_STAR;
        if (ch == "#") return GLYPH_HASH;
        return GLYPH_ALLON;
    endfunction

    // turn one accepted command into its segment writes, oldest first
    task automatic predict_writes(input t_in_item it);
        logic [2:0]  slots  [6];
        logic [5:0]  glyphs [6];
        int          n;
        int unsigned rest;
        int unsigned d;
        bit          seen;
        logic [7:0]  fbyte;
        t_out_item   w;
        n = 0;
        if (it.cmd == CMD_CHAR) begin
            // positions 0 and 7 are accepted but draw nothing
            if (it.position >= 3'd1 && it.position <= 3'd6) begin
                slots[0]  = it.position - 3'd1;
                glyphs[0] = char_glyph(it.char_code);
                n = 1;
                char_items++;
            end else begin
                blank_items++;
            end
        end else if (it.number_value >= ERROR_LIMIT) begin
            // too wide for six digits: the whole display reads " ERROR"
            for (int s = 0; s < 6; s++) begin
                slots[s]  = 3'(s);
                glyphs[s] = char_glyph(error_text[s]);
            end
            n = 6;
            error_items++;
        end else begin
            // right-aligned decimal, leading zeros blank, units digit always drawn
            rest = it.number_value;
            seen = 1'b0;
            for (int s = 0; s < 6; s++) begin
                d    = rest / dec_weight[s];
                rest = rest % dec_weight[s];
                if (d > 9) d = 9;
                slots[s] = 3'(s);
                if (d == 0 && !seen && s < 5) begin
                    glyphs[s] = GLYPH_SPACE;
                end else begin
                    seen      = 1'b1;
                    glyphs[s] = 6'(d);
                end
            end
            n = 6;
            number_items++;
        end
        // four writes per glyph: low then high nibble of byte 0, then of byte 1
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 4; k++) begin
                fbyte         = seg_font[glyphs[i]][k / 2];
                w.segment_pin = pos_pins[slots[i]][k];
                w.nibble      = (k % 2) ? fbyte[7:4] : fbyte[3:0];
                w.last_of_run = (i == n - 1) && (k == 3);
                pending_writes.push_back(w);
            end
        end
    endtask

    // offer one item after an optional gap and hold it until the block takes it
    task automatic send_item(input t_in_item it);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_writes(it);
    endtask

    // stop offering and let every predicted write come out
    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_writes.size() > 0) @(posedge i_clk);
    endtask

    // unused fields carry random bits so they toggle too
    function automatic t_in_item char_cmd(input logic [7:0] ch, input logic [2:0] pos);
        t_in_item it;
        it.cmd          = CMD_CHAR;
        it.char_code    = ch;
        it.position     = pos;
        it.number_value = $urandom;
        return it;
    endfunction

    function automatic t_in_item number_cmd(input logic [31:0] v);
        t_in_item it;
        it.cmd          = CMD_NUMBER;
        it.char_code    = 8'($urandom);
        it.position     = 3'($urandom);
        it.number_value = v;
        return it;
    endfunction

    function automatic t_in_item random_cmd();
        int       sel;
        t_in_item it;
        // characters: half from the font, half any code
        if ($urandom_range(0, 1)) begin
            sel = $urandom_range(0, 38);
            if (sel < 10)      it.char_code = 8'("0" + sel);
            else if (sel < 36) it.char_code = 8'("A" + sel - 10);
            else if (sel == 36) it.char_code = "*";
            else if (sel == 37) it.char_code = "#";
            else               it.char_code = " ";
        end else begin
            it.char_code = 8'($urandom_range(0, 255));
        end
        // positions mostly on the display, sometimes just off it
        if ($urandom_range(0, 9) < 8) it.position = 3'($urandom_range(1, 6));
        else                          it.position = $urandom_range(0, 1) ? 3'd7 : 3'd0;
        // numbers spread over digit counts, the error edge and the full range
        case ($urandom_range(0, 9))
            0:       it.number_value = $urandom_range(0, 9);
            1:       it.number_value = $urandom_range(0, 999);
            2:       it.number_value = $urandom_range(0, 99999);
            3, 4:    it.number_value = $urandom_range(0, 999999);
            5:       it.number_value = $urandom_range(999990, 1000010);
            6:       it.number_value = 32'(10 ** $urandom_range(0, 6));
            default: it.number_value = $urandom;
        endcase
        it.cmd = $urandom_range(0, 1) ? CMD_NUMBER : CMD_CHAR;
        return it;
    endfunction

    // ---------------------------------------------------------------- tests

    // blank, font edges, non-font codes and off-display positions
    task automatic test_char_cases();
        send_item(char_cmd(" ", 3'd1));
        send_item(char_cmd("0", 3'd6));
        send_item(char_cmd("9", 3'd2));
        send_item(char_cmd("A", 3'd3));
        send_item(char_cmd("Z", 3'd4));
        send_item(char_cmd("*", 3'd5));
        send_item(char_cmd("#", 3'd1));
        send_item(char_cmd("a", 3'd2));
        send_item(char_cmd(8'h00, 3'd3));
        send_item(char_cmd(8'hFF, 3'd6));
        send_item(char_cmd(8'h80, 3'd4));
        send_item(char_cmd("K", 3'd0));
        send_item(char_cmd("K", 3'd7));
        wait_drained();
    endtask

    // zero, full width, the error threshold and the top of the range
    task automatic test_number_cases();
        send_item(number_cmd(32'd0));
        send_item(number_cmd(32'd7));
        send_item(number_cmd(32'd10));
        send_item(number_cmd(32'd100000));
        send_item(number_cmd(32'd123456));
        send_item(number_cmd(32'd999999));
        send_item(number_cmd(32'd1000000));
        send_item(number_cmd(32'hFFFFFFFF));
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_backpressure();
        tx_gaps        = 1'b0;
        rx_hold_cycles = 250;
        for (int i = 0; i < 10; i++) begin
            send_item(i % 3 == 0 ? char_cmd("8", 3'(i % 6 + 1)) : number_cmd($urandom));
        end
        wait_drained();
        tx_gaps = 1'b1;
    endtask

    // bulk random mix with a stretch where neither side idles
    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++) begin
            tx_gaps   = !(i >= 120 && i < 180);
            rx_stalls = tx_gaps;
            send_item(random_cmd());
        end
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        wait_drained();
    endtask

    // ---------------------------------------------------------------- receiver

    // random stalls plus a long hold-off on request, counted down here
    initial begin : drive_ready
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (rx_stalls && $urandom_range(0, 99) < 20) stall_left = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------- checking

    // every write that leaves the block is matched against the oldest prediction
    always @(posedge i_clk) begin : check_writes
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            writes_seen++;
            if (pending_writes.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected write: pin %0d nibble %h last %0b",
                             out_ch.data.segment_pin, out_ch.data.nibble,
                             out_ch.data.last_of_run);
            end else begin
                want = pending_writes.pop_front();
                if (out_ch.data.segment_pin !== want.segment_pin ||
                    out_ch.data.nibble !== want.nibble ||
                    out_ch.data.last_of_run !== want.last_of_run) begin
                    mismatches++;
                    if (mismatches + unexpected <= 10)
                        $display("write mismatch: pin %0d/%0d nibble %h/%h last %0b/%0b (exp/got)",
                                 want.segment_pin, out_ch.data.segment_pin,
                                 want.nibble, out_ch.data.nibble,
                                 want.last_of_run, out_ch.data.last_of_run);
                end
            end
        end
    end

    // hang detection: nothing moving on either channel for too long
    always @(posedge i_clk) begin : watchdog
        int stuck_cycles;
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STUCK_LIMIT);
                $display("tb_segment_lcd_char_and_number_writer_unit failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_char_cases();
        test_number_cases();
        test_output_backpressure();
        test_random_mix(380);

        // let any stray write show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d char, %0d off-display, %0d number and %0d error items",
                 char_items, blank_items, number_items, error_items);
        $display("checked %0d segment writes, %0d mismatched, %0d unexpected",
                 writes_seen, mismatches, unexpected);
        if (mismatches == 0 && unexpected == 0 && pending_writes.size() == 0) begin
            $display("tb_segment_lcd_char_and_number_writer_unit passed");
        end else begin
            $display("tb_segment_lcd_char_and_number_writer_unit failed");
        end
        $finish;
    end

endmodule
